/* hdl/ogru_pkg.sv */
// Shared types, constants and cell arithmetic for the occupancy grid ray update unit.
// No dependencies; every other file of the block but ogru_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ogru_pkg;

   // grid geometry
   localparam int GRID_DIM   = 512;
   localparam int COORD_BITS = 12;
   localparam int CELLS      = GRID_DIM * GRID_DIM;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int CELL_W     = 8;

   // config field widths
   localparam int RANGE_W = 14;
   localparam int ODDS_W  = 7;
   localparam int GDIM_W  = 10;
   localparam int COUNT_W = 13;
   localparam int KIND_W  = 2;

   // width of the grid limit min(grid_width, GRID_DIM) and of the compare
   localparam int DIM_CLOG = $clog2(GRID_DIM + 1);
   localparam int LIM_W    = (GDIM_W > DIM_CLOG) ? GDIM_W : DIM_CLOG;
   localparam int CMP_W    = (LIM_W > COORD_BITS) ? LIM_W : COORD_BITS;

   // Bresenham error term and doubled error
   localparam int ERR_W = COORD_BITS + 2;
   localparam int E2_W  = COORD_BITS + 3;

   // range cutoffs in mm, compared as signed values
   localparam int THR_W          = RANGE_W + 2;
   localparam int EP_MARGIN_MM   = 200;
   localparam int EP_MIN_MM      = 50;
   localparam int RAY_MARGIN_MM  = 100;

   // stream packing
   localparam int RANGE_LSB   = 0;
   localparam int SX_LSB      = RANGE_LSB + RANGE_W;
   localparam int SY_LSB      = SX_LSB + COORD_BITS;
   localparam int EX_LSB      = SY_LSB + COORD_BITS;
   localparam int EY_LSB      = EX_LSB + COORD_BITS;
   localparam int REQ_BITS    = EY_LSB + COORD_BITS;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int VALUE_LSB   = 0;
   localparam int COUNT_LSB   = VALUE_LSB + CELL_W;
   localparam int RSP_BITS    = COUNT_LSB + COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ENDPOINT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RAY      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIT_ODDS    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MISS_ODDS   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd4;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 14'd5000;
   localparam logic [ODDS_W-1:0]  HIT_ODDS_RST  = 7'd3;
   localparam logic [ODDS_W-1:0]  MISS_ODDS_RST = 7'd1;
   localparam logic [GDIM_W-1:0]  GRID_DIM_RST  = 10'd512;

   typedef struct packed {
      logic [RANGE_W-1:0] max_range_mm;
      logic [ODDS_W-1:0]  hit_odds;
      logic [ODDS_W-1:0]  miss_odds;
      logic [GDIM_W-1:0]  grid_width;
      logic [GDIM_W-1:0]  grid_height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         at_end;
   } line_pos_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EP_WRITE,
      ST_RD_DATA,
      ST_RAY,
      ST_RESULT
   } state_type;

   function automatic logic coord_in_range(input logic signed [COORD_BITS-1:0] c,
                                           input logic [GDIM_W-1:0] dim);
      logic [LIM_W-1:0] lim;
      lim = (LIM_W'(dim) < LIM_W'(GRID_DIM)) ? LIM_W'(dim) : LIM_W'(GRID_DIM);
      return !c[COORD_BITS-1] && (CMP_W'($unsigned(c)) < CMP_W'(lim));
   endfunction

   function automatic logic cell_in_grid(input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y,
                                         input cfg_type cfg);
      return coord_in_range(x, cfg.grid_width) && coord_in_range(y, cfg.grid_height);
   endfunction

   // row-major address; only meaningful for cells inside the grid
   function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_BITS-1:0] x,
                                                   input logic signed [COORD_BITS-1:0] y);
      return ADDR_W'($unsigned(y)) * ADDR_W'(GRID_DIM) + ADDR_W'($unsigned(x));
   endfunction

   // hit: add and clamp at +127
   function automatic logic signed [CELL_W-1:0] raise_cell(input logic signed [CELL_W-1:0] c,
                                                           input logic [ODDS_W-1:0] odds);
      logic signed [CELL_W:0] v;
      v = {c[CELL_W-1], c} + $signed({2'b00, odds});
      return (v > 9'sd127) ? 8'sd127 : v[CELL_W-1:0];
   endfunction

   // miss: subtract; anything below -128 folds to -127
   function automatic logic signed [CELL_W-1:0] lower_cell(input logic signed [CELL_W-1:0] c,
                                                           input logic [ODDS_W-1:0] odds);
      logic signed [CELL_W:0] v;
      v = {c[CELL_W-1], c} - $signed({2'b00, odds});
      return (v < -9'sd128) ? -8'sd127 : v[CELL_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/ogru_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/ogru_csr.sv */
// APB-style configuration registers of the occupancy grid ray update unit.
// Depends on ogru_pkg for the register map and the cfg_type struct.
`timescale 1ns / 1ps
`default_nettype none

module ogru_csr
   import ogru_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_MAX_RANGE:   cfg_in.max_range_mm = pwdata[RANGE_W-1:0];
            REG_HIT_ODDS:    cfg_in.hit_odds     = pwdata[ODDS_W-1:0];
            REG_MISS_ODDS:   cfg_in.miss_odds    = pwdata[ODDS_W-1:0];
            REG_GRID_WIDTH:  cfg_in.grid_width   = pwdata[GDIM_W-1:0];
            REG_GRID_HEIGHT: cfg_in.grid_height  = pwdata[GDIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_range_mm <= MAX_RANGE_RST;
         cfg_ff.hit_odds     <= HIT_ODDS_RST;
         cfg_ff.miss_odds    <= MISS_ODDS_RST;
         cfg_ff.grid_width   <= GRID_DIM_RST;
         cfg_ff.grid_height  <= GRID_DIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_MAX_RANGE:   prdata = CSR_DATA_W'(cfg_ff.max_range_mm);
         REG_HIT_ODDS:    prdata = CSR_DATA_W'(cfg_ff.hit_odds);
         REG_MISS_ODDS:   prdata = CSR_DATA_W'(cfg_ff.miss_odds);
         REG_GRID_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.grid_height);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hdl/ogru_line.sv */
// Bresenham line stepper: loads a start and end cell, advances one cell per step.
// Depends on ogru_pkg for coordinate widths and line_pos_type.
`timescale 1ns / 1ps
`default_nettype none

module ogru_line
   import ogru_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic                         step,
   input  wire logic signed [COORD_BITS-1:0] x0,
   input  wire logic signed [COORD_BITS-1:0] y0,
   input  wire logic signed [COORD_BITS-1:0] x1,
   input  wire logic signed [COORD_BITS-1:0] y1,
   output line_pos_type                      pos
);

   logic signed [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff;
   logic        [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic                         xneg_ff, xneg_in, yneg_ff, yneg_in;

   logic signed [COORD_BITS:0] diff_x, diff_y;
   logic signed [E2_W-1:0]     e2, dx_s, dy_s;
   logic                       x_move, y_move;

   assign diff_x = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
   assign diff_y = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};

   assign e2     = {err_ff, 1'b0};
   assign dx_s   = $signed(E2_W'(dx_ff));
   assign dy_s   = $signed(E2_W'(dy_ff));
   assign x_move = (e2 >= -dy_s);
   assign y_move = (e2 <= dx_s);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      err_in  = err_ff;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      if (load) begin
         xneg_in = diff_x[COORD_BITS];
         yneg_in = diff_y[COORD_BITS];
         dx_in   = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
         dy_in   = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
         err_in  = $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));
         x_in    = x0;
         y_in    = y0;
      end else if (step) begin
         err_in = ERR_W'(e2[E2_W-1:1]
                         - (x_move ? dy_s[E2_W-2:0] : '0)
                         + (y_move ? dx_s[E2_W-2:0] : '0));
         if (x_move) begin
            x_in = xneg_ff ? x_ff - COORD_BITS'(1) : x_ff + COORD_BITS'(1);
         end
         if (y_move) begin
            y_in = yneg_ff ? y_ff - COORD_BITS'(1) : y_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      err_ff  <= err_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
      if (load) begin
         x1_ff <= x1;
         y1_ff <= y1;
      end
   end

   assign pos.x      = x_ff;
   assign pos.y      = y_ff;
   assign pos.at_end = (x_ff == x1_ff) && (y_ff == y1_ff);

endmodule

`default_nettype wire

/* hdl/occupancy_grid_ray_update_unit.sv */
// Top level of the occupancy grid ray update unit: control sequencer, grid RAM,
// line stepper and config registers. Depends on ogru_pkg, ogru_ram, ogru_line, ogru_csr.
//
//  channel | dir | handshake               | contents
//  --------+-----+-------------------------+------------------------------------------
//  req_    | in  | tvalid/tready           | tuser: kind; tdata: range, start, end cell
//  rsp_    | out | tvalid/tready           | tuser: skipped; tdata: value, cells changed
//  csr_    | in  | psel/penable, pready=1  | five config registers at 4*i
//
//  After reset the grid RAM is swept to zero, one cell a cycle, all 262144
//  (GRID_DIM*GRID_DIM) cells, during which req_tready is low; csr writes are taken.
//  In-grid endpoint and read words pass through accept, RAM read/modify and result.
//  A ray word walks the N = max(|dx|,|dy|) cells before its end cell, one cell per
//  cycle through the single read port of the grid RAM, write-back in the cycle after.
//  Skipped, off-grid and unused-kind words go from accept straight to result. A
//  waiting rsp word does not block the next accept; only the hand-off of the
//  following result waits on rsp_tready.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_ray_update_unit
   import ogru_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] kind
   input  wire logic [KIND_W-1:0]     req_tuser,
   // [13:0] range_mm, [25:14] start_x, [37:26] start_y, [49:38] end_x, [61:50] end_y
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] skipped
   output logic [0:0]                 rsp_tuser,
   // [7:0] cell_value, [20:8] cells_changed
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // config port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   ogru_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // request fields
   logic [KIND_W-1:0]            in_kind;
   logic [RANGE_W-1:0]           in_range;
   logic signed [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;

   assign in_kind  = req_tuser;
   assign in_range = req_tdata[RANGE_LSB +: RANGE_W];
   assign in_sx    = $signed(req_tdata[SX_LSB +: COORD_BITS]);
   assign in_sy    = $signed(req_tdata[SY_LSB +: COORD_BITS]);
   assign in_ex    = $signed(req_tdata[EX_LSB +: COORD_BITS]);
   assign in_ey    = $signed(req_tdata[EY_LSB +: COORD_BITS]);

   // range cutoffs, signed so a small max_range rejects everything
   logic signed [THR_W-1:0] rng_s, maxr_s;
   logic                    ep_skip, ray_skip;

   assign rng_s    = $signed(THR_W'(in_range));
   assign maxr_s   = $signed(THR_W'(cfg.max_range_mm));
   assign ep_skip  = (rng_s >= maxr_s - THR_W'(EP_MARGIN_MM))
                     || (rng_s <= THR_W'(EP_MIN_MM));
   assign ray_skip = (rng_s >= maxr_s - THR_W'(RAY_MARGIN_MM));

   logic ep_ok, rd_ok;
   assign ep_ok = cell_in_grid(in_ex, in_ey, cfg);
   assign rd_ok = cell_in_grid(in_sx, in_sy, cfg);

   // grid RAM
   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
   logic signed [CELL_W-1:0] mem_wdata, mem_rdata;

   ogru_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // line stepper
   logic         line_load, line_step;
   line_pos_type pos;

   ogru_line u_line (
      .clock (clock),
      .load  (line_load),
      .step  (line_step),
      .x0    (in_sx),
      .y0    (in_sy),
      .x1    (in_ex),
      .y1    (in_ey),
      .pos   (pos)
   );

   logic              pos_ok;
   logic [ADDR_W-1:0] pos_addr;
   assign pos_ok   = cell_in_grid(pos.x, pos.y, cfg);
   assign pos_addr = cell_addr(pos.x, pos.y);

   // control state
   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic                     pend_ff, pend_in;        // ray cell read, write-back due
   logic [ADDR_W-1:0]        pend_addr_ff, pend_addr_in;
   logic signed [CELL_W-1:0] res_value_ff, res_value_in;
   logic [COUNT_W-1:0]       res_count_ff, res_count_in;
   logic                     res_skip_ff, res_skip_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CELL_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_skip_ff;
   logic                     req_fire, rsp_load, clr_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_tready);
   assign clr_last   = (clr_ff == ADDR_W'(CELLS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (in_kind)
                  KIND_ENDPOINT: state_in = (!ep_skip && ep_ok) ? ST_EP_WRITE : ST_RESULT;
                  KIND_RAY:      state_in = ray_skip ? ST_RESULT : ST_RAY;
                  KIND_READ:     state_in = rd_ok ? ST_RD_DATA : ST_RESULT;
                  default:       state_in = ST_RESULT;
               endcase
            end
         end
         ST_EP_WRITE: state_in = ST_RESULT;
         ST_RD_DATA:  state_in = ST_RESULT;
         ST_RAY: begin
            if (pos.at_end) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = pos_addr;
      line_load    = 1'b0;
      line_step    = 1'b0;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      res_value_in = res_value_ff;
      res_count_in = res_count_ff;
      res_skip_in  = res_skip_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_value_in = '0;
               res_count_in = '0;
               res_skip_in  = 1'b0;
               pend_in      = 1'b0;
               case (in_kind)
                  KIND_ENDPOINT: begin
                     res_skip_in = ep_skip;
                     addr_in     = cell_addr(in_ex, in_ey);
                     mem_raddr   = addr_in;
                     mem_re      = !ep_skip && ep_ok;
                  end
                  KIND_RAY: begin
                     res_skip_in = ray_skip;
                     line_load   = 1'b1;
                  end
                  KIND_READ: begin
                     mem_raddr = cell_addr(in_sx, in_sy);
                     mem_re    = rd_ok;
                  end
                  default: ;
               endcase
            end
         end
         ST_EP_WRITE: begin
            mem_we       = 1'b1;
            mem_wdata    = raise_cell(mem_rdata, cfg.hit_odds);
            res_value_in = mem_wdata;
            res_count_in = COUNT_W'(1);
         end
         ST_RD_DATA: begin
            res_value_in = mem_rdata;
         end
         ST_RAY: begin
            // write back the cell read last cycle while reading the next one
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = lower_cell(mem_rdata, cfg.miss_odds);
            end
            if (pos.at_end) begin
               pend_in = 1'b0;
            end else begin
               line_step    = 1'b1;
               mem_re       = pos_ok;
               pend_in      = pos_ok;
               pend_addr_in = pos_addr;
               if (pos_ok) begin
                  res_count_in = res_count_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      res_value_ff <= res_value_in;
      res_count_ff <= res_count_in;
      res_skip_ff  <= res_skip_in;
      if (rsp_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_count_ff <= res_count_ff;
         rsp_skip_ff  <= res_skip_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_skip_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_value_ff});

   // read and write-back of a ray never hit the same cell in one cycle
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("grid RAM read and write to the same cell");

   // a new response only comes out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");

   // a skipped word never reports writes or a value
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_count_ff == '0 && rsp_value_ff == '0)
      else $error("skipped word carries data");

   // pending write-back only lives inside a ray walk
   a_pend_in_ray: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_RAY)
      else $error("write-back pending outside ray walk");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for occupancy_grid_ray_update_unit: a shadow log-odds grid
// predicts every response word. Needs ogru_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top
   import ogru_pkg::*;
();

   // kind code that the block must ignore
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   // limit covers the clear sweep, ~1050 words and a handful of full-length rays
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [KIND_W-1:0]            kind;
      logic [RANGE_W-1:0]           range_mm;
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] sy;
      logic signed [COORD_BITS-1:0] ex;
      logic signed [COORD_BITS-1:0] ey;
   } ray_cmd_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] cell_value;
      logic [COUNT_W-1:0]       cells_changed;
      logic                     skipped;
   } grid_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [KIND_W-1:0]       req_tuser = '0;      // [1:0] kind
   // [13:0] range_mm, [25:14] start_x, [37:26] start_y, [49:38] end_x, [61:50] end_y
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [0:0]              rsp_tuser;           // [0] skipped
   logic [RSP_DATA_W-1:0]   rsp_tdata;           // [7:0] cell_value, [20:8] cells_changed
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   occupancy_grid_ray_update_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow state: grid contents and register copies (reset values to start)
   // ---------------------------------------------------------------------------
   logic signed [CELL_W-1:0] odds_mirror [0:CELLS-1];
   int cfg_max_range = 5000;
   int cfg_hit       = 3;
   int cfg_miss      = 1;
   int cfg_gw        = 512;
   int cfg_gh        = 512;

   ray_cmd_type     scan_cmd_q[$];     // words waiting for the driver
   grid_result_type odds_expect_q[$];  // predicted responses, oldest first
   logic [2*COORD_BITS-1:0] recent_ends[$];  // end cells worth reading back

   int  fail_count  = 0;
   int  cycle_count = 0;
   logic req_taken = 1'b0;          // req word accepted at the last rising edge

   function automatic bit cell_inside(input int x, input int y);
      int w, h;
      w = (cfg_gw < GRID_DIM) ? cfg_gw : GRID_DIM;
      h = (cfg_gh < GRID_DIM) ? cfg_gh : GRID_DIM;
      return x >= 0 && y >= 0 && x < w && y < h;
   endfunction

   // Applies one accepted word to the shadow grid and returns its response.
   function automatic grid_result_type apply_scan_cmd(input ray_cmd_type c);
      grid_result_type r;
      int x, y, x1, y1, dx, dy, stx, sty, err, e2, n, v, rng;
      r   = '0;
      rng = int'(c.range_mm);
      case (c.kind)
         KIND_ENDPOINT: begin
            x1 = int'(c.ex);
            y1 = int'(c.ey);
            if (rng >= cfg_max_range - EP_MARGIN_MM || rng <= EP_MIN_MM) begin
               r.skipped = 1'b1;
            end else if (cell_inside(x1, y1)) begin
               v = int'(odds_mirror[y1 * GRID_DIM + x1]) + cfg_hit;
               if (v > 127) v = 127;     // hits saturate
               odds_mirror[y1 * GRID_DIM + x1] = v[CELL_W-1:0];
               r.cell_value    = v[CELL_W-1:0];
               r.cells_changed = COUNT_W'(1);
            end
         end
         KIND_RAY: begin
            if (rng >= cfg_max_range - RAY_MARGIN_MM) begin
               r.skipped = 1'b1;
            end else begin
               x   = int'(c.sx);
               y   = int'(c.sy);
               x1  = int'(c.ex);
               y1  = int'(c.ey);
               dx  = (x1 > x) ? x1 - x : x - x1;
               dy  = (y1 > y) ? y1 - y : y - y1;
               stx = (x1 > x) ? 1 : ((x1 < x) ? -1 : 0);
               sty = (y1 > y) ? 1 : ((y1 < y) ? -1 : 0);
               err = dx - dy;
               n   = 0;
               // every in-grid cell on the line but the end one takes a miss
               while (x != x1 || y != y1) begin
                  e2 = 2 * err;
                  if (cell_inside(x, y)) begin
                     v = int'(odds_mirror[y * GRID_DIM + x]) - cfg_miss;
                     if (v < -128) v = -127;   // underflow folds to -127, -128 itself stays
                     odds_mirror[y * GRID_DIM + x] = v[CELL_W-1:0];
                     n++;
                  end
                  if (e2 >= -dy) begin
                     err -= dy;
                     x   += stx;
                  end
                  if (e2 <= dx) begin
                     err += dx;
                     y   += sty;
                  end
               end
               r.cells_changed = n[COUNT_W-1:0];
            end
         end
         KIND_READ: begin
            x = int'(c.sx);
            y = int'(c.sy);
            if (cell_inside(x, y)) r.cell_value = odds_mirror[y * GRID_DIM + x];
         end
         default: ;  // spare kind: all-zero response
      endcase
      return r;
   endfunction

   function automatic int reg_value(input logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_MAX_RANGE:   return cfg_max_range;
         REG_HIT_ODDS:    return cfg_hit;
         REG_MISS_ODDS:   return cfg_miss;
         REG_GRID_WIDTH:  return cfg_gw;
         REG_GRID_HEIGHT: return cfg_gh;
         default:         return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic ray_cmd_type make_cmd(input logic [KIND_W-1:0] kind, input int rng,
                                            input int sx, input int sy,
                                            input int ex, input int ey);
      ray_cmd_type c;
      c.kind     = kind;
      c.range_mm = rng[RANGE_W-1:0];
      c.sx       = sx[COORD_BITS-1:0];
      c.sy       = sy[COORD_BITS-1:0];
      c.ex       = ex[COORD_BITS-1:0];
      c.ey       = ey[COORD_BITS-1:0];
      return c;
   endfunction

   // appends one word to the driver's queue
   task automatic queue_cmd(input ray_cmd_type c);
      scan_cmd_q = {scan_cmd_q, c};
   endtask

   // Mostly a small hot corner so cells pile up, some near the far grid edge,
   // some anywhere in the coordinate space.
   function automatic int pick_coord(input int dim);
      int lim, hot, r;
      lim = (dim < GRID_DIM) ? dim : GRID_DIM;
      hot = (lim < 24) ? lim : 24;
      r   = $urandom_range(0, 99);
      if (r < 65) return int'($urandom_range(0, hot + 1)) - 1;
      if (r < 85) return lim - 3 + int'($urandom_range(0, 5));
      return int'($signed($urandom_range(0, 4095) << 20)) >>> 20;
   endfunction

   // Range mostly inside the accept window, else right on a cutoff, else anything.
   function automatic int pick_range(input bit for_endpoint);
      int lo, hi, r, v;
      lo = for_endpoint ? EP_MIN_MM + 1 : 0;
      hi = cfg_max_range - (for_endpoint ? EP_MARGIN_MM + 1 : RAY_MARGIN_MM + 1);
      r  = $urandom_range(0, 99);
      if (r < 75 && hi >= lo) begin
         v = $urandom_range(lo, hi);
      end else if (r < 92) begin
         case ($urandom_range(0, 5))
            0:       v = EP_MIN_MM;
            1:       v = EP_MIN_MM + 1;
            2:       v = cfg_max_range - EP_MARGIN_MM - 1;
            3:       v = cfg_max_range - EP_MARGIN_MM;
            4:       v = cfg_max_range - RAY_MARGIN_MM - 1;
            default: v = cfg_max_range - RAY_MARGIN_MM;
         endcase
         if (v < 0) v = 0;
      end else begin
         v = $urandom_range(0, 16383);
      end
      return v;
   endfunction

   // Random traffic: mostly scans (a ray then its endpoint on the same geometry),
   // plus lone hits, lone rays, read-backs and spare-kind noise.
   task automatic queue_random_scans(input int n);
      int made, r, sx, sy, ex, ey, rng;
      logic [2*COORD_BITS-1:0] end_cell;
      made = 0;
      while (made < n) begin
         sx = pick_coord(cfg_gw);
         sy = pick_coord(cfg_gh);
         r  = $urandom_range(0, 99);
         if (r < 84) begin
            ex = sx + int'($urandom_range(0, 24)) - 12;
            ey = sy + int'($urandom_range(0, 24)) - 12;
         end else if (r < 98) begin
            ex = sx + int'($urandom_range(0, 600)) - 300;
            ey = sy + int'($urandom_range(0, 600)) - 300;
         end else begin
            // rare long ray, up to thousands of cells
            ex = pick_coord(4096);
            ey = int'($signed($urandom_range(0, 4095) << 20)) >>> 20;
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rng = pick_range(1'b1);
            queue_cmd(make_cmd(KIND_RAY, rng, sx, sy, ex, ey));
            queue_cmd(make_cmd(KIND_ENDPOINT, rng, sx, sy, ex, ey));
            made += 2;
         end else if (r < 65) begin
            queue_cmd(make_cmd(KIND_ENDPOINT, pick_range(1'b1), sx, sy, ex, ey));
            made++;
         end else if (r < 75) begin
            queue_cmd(make_cmd(KIND_RAY, pick_range(1'b0), sx, sy, ex, ey));
            made++;
         end else if (r < 95) begin
            if (recent_ends.size() > 0 && $urandom_range(0, 2) != 0) begin
               end_cell = recent_ends[$urandom_range(0, recent_ends.size() - 1)];
               sx       = int'($signed(end_cell[2*COORD_BITS-1:COORD_BITS]));
               sy       = int'($signed(end_cell[COORD_BITS-1:0]));
            end
            queue_cmd(make_cmd(KIND_READ, $urandom, sx, sy, ex, ey));
            made++;
         end else begin
            queue_cmd(make_cmd(KIND_SPARE, $urandom, $urandom, $urandom,
                               $urandom, $urandom));
         end
         end_cell    = {ex[COORD_BITS-1:0], ey[COORD_BITS-1:0]};
         recent_ends = {recent_ends, end_cell};
         if (recent_ends.size() > 8) void'(recent_ends.pop_front());
      end
   endtask

   // ---------------------------------------------------------------------------
   // Config port: setup cycle, access cycle; shadow copy follows the write
   // ---------------------------------------------------------------------------
   task automatic csr_access(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value,
                             input bit is_write);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= is_write ? value : '0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (is_write) begin
         case (idx)
            REG_MAX_RANGE:   cfg_max_range = int'(value[RANGE_W-1:0]);
            REG_HIT_ODDS:    cfg_hit       = int'(value[ODDS_W-1:0]);
            REG_MISS_ODDS:   cfg_miss      = int'(value[ODDS_W-1:0]);
            REG_GRID_WIDTH:  cfg_gw        = int'(value[GDIM_W-1:0]);
            REG_GRID_HEIGHT: cfg_gh        = int'(value[GDIM_W-1:0]);
            default: ;
         endcase
      end
   endtask

   // Idle = nothing queued, nothing on the wire, no response owed. Checked at the
   // rising edge, where the driver's queue and req_tvalid are settled.
   task automatic wait_idle();
      while (scan_cmd_q.size() != 0 || req_tvalid || odds_expect_q.size() != 0)
         @(posedge clock);
      // settle margin; the last ray write-back already lands before its response word
      repeat (8) @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] max_range, input logic [31:0] hit,
                             input logic [31:0] miss, input logic [31:0] width,
                             input logic [31:0] height);
      wait_idle();
      csr_access(REG_MAX_RANGE,   max_range, 1'b1);
      csr_access(REG_HIT_ODDS,    hit,       1'b1);
      csr_access(REG_MISS_ODDS,   miss,      1'b1);
      csr_access(REG_GRID_WIDTH,  width,     1'b1);
      csr_access(REG_GRID_HEIGHT, height,    1'b1);
      // read everything back; the monitor checks prdata
      csr_access(REG_MAX_RANGE,   '0, 1'b0);
      csr_access(REG_HIT_ODDS,    '0, 1'b0);
      csr_access(REG_MISS_ODDS,   '0, 1'b0);
      csr_access(REG_GRID_WIDTH,  '0, 1'b0);
      csr_access(REG_GRID_HEIGHT, '0, 1'b0);
      // queue fills happen away from the driver's falling edge
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: bursts of req words with random gaps, changes on the falling edge
   // ---------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : req_driver
      ray_cmd_type nxt;
      logic [REQ_DATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (scan_cmd_q.size() > 0) begin
            nxt  = scan_cmd_q.pop_front();
            word = '0;
            word[RANGE_LSB +: RANGE_W] = nxt.range_mm;
            word[SX_LSB +: COORD_BITS] = nxt.sx;
            word[SY_LSB +: COORD_BITS] = nxt.sy;
            word[EX_LSB +: COORD_BITS] = nxt.ex;
            word[EY_LSB +: COORD_BITS] = nxt.ey;
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.kind;
            req_tdata  <= word;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               // about a third of bursts run straight into the next one
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: rsp_tready follows a rotating 16-bit pattern, reshuffled now and
   // then; bit 0 of a random pattern is forced so that it always holds ready cycles
   // ---------------------------------------------------------------------------
   logic [15:0] stall_pat = 16'hFFFF;
   int          stall_age = 0;

   always @(negedge clock) begin
      if (stall_age == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pat <= 16'hFFFF;
            1:       stall_pat <= 16'(($urandom & 16'hFFFF) | 16'h0001);
            2:       stall_pat <= 16'h8000;
            default: stall_pat <= 16'hAAAA;
         endcase
         stall_age <= $urandom_range(50, 400);
      end else begin
         stall_pat <= {stall_pat[14:0], stall_pat[15]};
         stall_age <= stall_age - 1;
      end
      rsp_tready <= stall_pat[15];
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on req accept, compare on rsp accept, check csr reads
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ray_cmd_type     cmd;
      grid_result_type want, got;
      int              reg_want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            cmd.kind     = req_tuser;
            cmd.range_mm = req_tdata[RANGE_LSB +: RANGE_W];
            cmd.sx       = req_tdata[SX_LSB +: COORD_BITS];
            cmd.sy       = req_tdata[SY_LSB +: COORD_BITS];
            cmd.ex       = req_tdata[EX_LSB +: COORD_BITS];
            cmd.ey       = req_tdata[EY_LSB +: COORD_BITS];
            odds_expect_q = {odds_expect_q, apply_scan_cmd(cmd)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.cell_value    = rsp_tdata[VALUE_LSB +: CELL_W];
            got.cells_changed = rsp_tdata[COUNT_LSB +: COUNT_W];
            got.skipped       = rsp_tuser[0];
            if (odds_expect_q.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = odds_expect_q.pop_front();
               if (got.cell_value !== want.cell_value) begin
                  $error("cell_value: expected %0d, got %0d", want.cell_value,
                         got.cell_value);
                  fail_count++;
               end
               if (got.cells_changed !== want.cells_changed) begin
                  $error("cells_changed: expected %0d, got %0d", want.cells_changed,
                         got.cells_changed);
                  fail_count++;
               end
               if (got.skipped !== want.skipped) begin
                  $error("skipped: expected %0d, got %0d", want.skipped, got.skipped);
                  fail_count++;
               end
            end
         end
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            reg_want = reg_value(csr_paddr[REG_IDX_W+1:2]);
            if (csr_prdata !== CSR_DATA_W'(reg_want)) begin
               $error("csr_prdata: expected %0d, got %0d", reg_want, csr_prdata);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[occupancy_grid_ray_update_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence: one phase per register setting
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < CELLS; i++) odds_mirror[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values, written explicitly; block is still sweeping its RAM
      set_config(5000, 3, 1, 512, 512);
      // directed words: range cutoffs, grid edges, ray shapes
      queue_cmd(make_cmd(KIND_READ,     0,     0, 0, 0, 0));
      queue_cmd(make_cmd(KIND_ENDPOINT, 1000,  0, 0, 5, 5));
      queue_cmd(make_cmd(KIND_ENDPOINT, 51,    0, 0, 5, 5));   // just above min
      queue_cmd(make_cmd(KIND_ENDPOINT, 50,    0, 0, 5, 5));   // at min: skip
      queue_cmd(make_cmd(KIND_ENDPOINT, 4799,  0, 0, 5, 5));   // just in
      queue_cmd(make_cmd(KIND_ENDPOINT, 4800,  0, 0, 5, 5));   // at margin: skip
      queue_cmd(make_cmd(KIND_ENDPOINT, 16383, 0, 0, 5, 5));
      queue_cmd(make_cmd(KIND_ENDPOINT, 1000,  0, 0, -1, 5));  // off grid
      queue_cmd(make_cmd(KIND_ENDPOINT, 1000,  0, 0, 511, 511));
      queue_cmd(make_cmd(KIND_ENDPOINT, 1000,  0, 0, 512, 0)); // off grid
      queue_cmd(make_cmd(KIND_RAY,      4899,  0, 5, 5, 5));
      queue_cmd(make_cmd(KIND_RAY,      4900,  0, 5, 5, 5));   // ray margin: skip
      queue_cmd(make_cmd(KIND_RAY,      100,   3, 3, 3, 3));   // zero length
      queue_cmd(make_cmd(KIND_RAY,      100,   -3, -3, 4, 4));
      queue_cmd(make_cmd(KIND_RAY,      100,   10, 0, 12, 20)); // steep
      queue_cmd(make_cmd(KIND_RAY,      100,   505, 505, 520, 515));
      queue_cmd(make_cmd(KIND_RAY,      100,   -2048, -2048, 2047, 2047));
      queue_cmd(make_cmd(KIND_RAY,      100,   2047, -2048, -2048, 2047));
      queue_cmd(make_cmd(KIND_READ,     0,     5, 5, 0, 0));
      queue_cmd(make_cmd(KIND_READ,     0,     2, 5, 0, 0));
      queue_cmd(make_cmd(KIND_SPARE,    16383, -1, -1, -1, -1));
      queue_random_scans(200);

      // top of every range; width/height above GRID_DIM clip to the array
      set_config(16383, 127, 127, 1023, 1023);
      queue_random_scans(180);

      // all zero: every hit and ray is cut, no cell is in the grid
      set_config(0, 0, 0, 0, 0);
      queue_random_scans(40);

      // large miss to land on the floor: -64, exactly -128 (kept), then -127
      set_config(300, 40, 64, 512, 512);
      queue_cmd(make_cmd(KIND_RAY,  0, 300, 200, 302, 200));
      queue_cmd(make_cmd(KIND_RAY,  0, 300, 200, 302, 200));
      queue_cmd(make_cmd(KIND_READ, 0, 300, 200, 0, 0));
      queue_cmd(make_cmd(KIND_RAY,  0, 300, 200, 302, 200));
      queue_cmd(make_cmd(KIND_READ, 0, 300, 200, 0, 0));
      queue_random_scans(170);

      // small grid and a narrow endpoint window (51..59 mm)
      set_config(260, 1, 5, 20, 9);
      queue_random_scans(170);

      // random registers, upper pwdata bits included
      set_config($urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random_scans(150);

      // single-column grid
      set_config(16383, 64, 3, 1, 512);
      queue_random_scans(130);

      wait_idle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && odds_expect_q.size() == 0) begin
         $display("[occupancy_grid_ray_update_unit] OK");
      end else begin
         $display("[occupancy_grid_ray_update_unit] ERROR");
      end
      $finish;
   end

endmodule
